@@ src/bds_pkg.sv @@
// bds_pkg: shared constants and types for the 2x2 box downsampler.
// No dependencies; imported by every module of the block except the RAM.
package bds_pkg;

  localparam int PAGE_DIM  = 256;
  localparam int CNT_W     = $clog2(2 * PAGE_DIM);
  localparam int ADDR_W    = $clog2(PAGE_DIM);
  localparam int PIX_W     = 24;
  localparam int LANE_W    = 9;
  localparam int NUM_LANES = 3;
  localparam int SUM_W     = LANE_W * NUM_LANES;
  localparam int CHAN_W    = 8;

  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(2 * PAGE_DIM - 1);

  typedef enum logic [1:0] {
    MODE_RGB     = 2'd0,
    MODE_GREY8   = 2'd1,
    MODE_GREY16U = 2'd2,
    MODE_GREY16S = 2'd3
  } pixel_mode_e;

  // lane adder results handed to the merge stage
  typedef struct packed {
    logic [SUM_W-1:0]     sum;
    logic [NUM_LANES-1:0] carry;
    logic                 ext;    // bit 27 of the signed 28-bit sum
  } lane_sum_t;

endpackage

@@ src/bds_ram.sv @@
// bds_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bds_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bds_lane.sv @@
// bds_lane: one 9-bit adder lane with carry in and out.
// Depends on bds_pkg for the lane width.
module bds_lane
  import bds_pkg::*;
(
  input  logic [LANE_W-1:0] a_i,
  input  logic [LANE_W-1:0] b_i,
  input  logic              cin_i,
  output logic [LANE_W-1:0] sum_o,
  output logic              cout_o
);

  logic [LANE_W:0] full;

  assign full   = {1'b0, a_i} + {1'b0, b_i} + {{LANE_W{1'b0}}, cin_i};
  assign sum_o  = full[LANE_W-1:0];
  assign cout_o = full[LANE_W];

endmodule

@@ src/bds_merge.sv @@
// bds_merge: combines the lane sums of a 2x2 block into the averaged word.
// Depends on bds_pkg for the mode enum and lane_sum_t.
module bds_merge
  import bds_pkg::*;
(
  input  pixel_mode_e      mode_i,
  input  lane_sum_t        lanes_i,
  output logic [PIX_W-1:0] pixel_o
);

  logic [15:0] sq;
  logic        round_up;

  // signed mode: divide by four toward zero
  assign round_up = lanes_i.ext & (|lanes_i.sum[1:0]);
  assign sq       = lanes_i.sum[17:2] + {15'd0, round_up};

  always_comb begin
    pixel_o = '0;
    unique case (mode_i)
      MODE_RGB: begin
        for (int k = 0; k < NUM_LANES; k++) begin
          pixel_o[CHAN_W*k +: CHAN_W] = {lanes_i.carry[k], lanes_i.sum[LANE_W*k+2 +: 7]};
        end
      end
      MODE_GREY8:   pixel_o = {16'd0, lanes_i.sum[9:2]};
      MODE_GREY16U: pixel_o = {8'd0, lanes_i.sum[17:2]};
      MODE_GREY16S: pixel_o = {8'd0, sq};
      default:      pixel_o = '0;
    endcase
  end

endmodule

@@ src/box_downsample_2x2.sv @@
// box_downsample_2x2: 2x2 box-filter downsampler, top level.
// Depends on bds_pkg, bds_ram, bds_lane and bds_merge.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid_i, in_stall_o, source_pixel_i    | in
//   output  | out_valid_o, out_stall_i, averaged_pixel_o, tile_done_o | out
//   config  | cfg_we_i, cfg_wdata_i                     | in
//
// One word per cycle in while not stalled; results pass the stage 2 and output registers.
// Pair sums run in stage 1, block sums and averaging in stage 2, then the output register.
// The line store is read with the even-column word of an odd row, one word ahead of use.
// Reset clears counters, pair sum, mode and valids; the line store is not cleared.
// Input stalls only while stage 2 holds a word the stalled output register cannot take.
module box_downsample_2x2
  import bds_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PIX_W-1:0] source_pixel_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] averaged_pixel_o,
  output logic             tile_done_o
);

  function automatic logic [SUM_W-1:0] pixel_term(input logic [PIX_W-1:0] p,
                                                  input pixel_mode_e m);
    logic [SUM_W-1:0] r;
    r = '0;
    unique case (m)
      MODE_RGB:     r = {1'b0, p[23:16], 1'b0, p[15:8], 1'b0, p[7:0]};
      MODE_GREY8:   r = {19'd0, p[7:0]};
      MODE_GREY16U: r = {11'd0, p[15:0]};
      MODE_GREY16S: r = {{11{p[15]}}, p[15:0]};
      default:      r = '0;
    endcase
    return r;
  endfunction

  pixel_mode_e      mode_q;
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [SUM_W-1:0] pair_q, pair_d;
  logic [SUM_W-1:0] term, pair_new, top_rd;
  logic [ADDR_W-1:0] line_addr;
  logic             chain, accept, emit, odd_col, odd_row, ram_we, ram_re;

  logic             s2_valid_q, s2_valid_d, s2_done_q;
  logic [SUM_W-1:0] s2_top_q, s2_bot_q, blk_sum;
  lane_sum_t        blk;

  logic             out_valid_q, out_done_q, out_ready;
  logic [PIX_W-1:0] out_pix_q, out_pix_d;

  logic [NUM_LANES:0] pc, bc;

  assign chain     = (mode_q != MODE_RGB);
  assign out_ready = !out_valid_q || !out_stall_i;
  assign in_stall_o = s2_valid_q && !out_ready;
  assign accept    = in_valid_i && !in_stall_o;
  assign odd_col   = col_q[0];
  assign odd_row   = row_q[0];
  assign line_addr = col_q[CNT_W-1:1];
  assign ram_we    = accept && odd_col && !odd_row;
  assign ram_re    = accept && !odd_col && odd_row;
  assign emit      = accept && odd_col && odd_row;
  assign term      = pixel_term(source_pixel_i, mode_q);

  // stage 1 lanes: horizontal pair sum; stage 2 lanes: vertical block sum
  assign pc[0] = 1'b0;
  assign bc[0] = 1'b0;
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    bds_lane u_pair (
      .a_i    (pair_q[LANE_W*k +: LANE_W]),
      .b_i    (term[LANE_W*k +: LANE_W]),
      .cin_i  (pc[k] & chain),
      .sum_o  (pair_new[LANE_W*k +: LANE_W]),
      .cout_o (pc[k+1])
    );
    bds_lane u_blk (
      .a_i    (s2_top_q[LANE_W*k +: LANE_W]),
      .b_i    (s2_bot_q[LANE_W*k +: LANE_W]),
      .cin_i  (bc[k] & chain),
      .sum_o  (blk_sum[LANE_W*k +: LANE_W]),
      .cout_o (bc[k+1])
    );
    assign blk.carry[k] = bc[k+1];
  end

  assign blk.sum = blk_sum;
  assign blk.ext = s2_top_q[SUM_W-1] ^ s2_bot_q[SUM_W-1] ^ bc[NUM_LANES];

  bds_ram #(
    .WIDTH (SUM_W),
    .DEPTH (PAGE_DIM)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (line_addr),
    .wdata_i (pair_new),
    .re_i    (ram_re),
    .raddr_i (line_addr),
    .rdata_o (top_rd)
  );

  bds_merge u_merge (
    .mode_i  (mode_q),
    .lanes_i (blk),
    .pixel_o (out_pix_d)
  );

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pair_d = pair_q;
    if (accept) begin
      pair_d = odd_col ? pair_new : term;
      if (col_q >= LAST_POS) begin
        col_d = '0;
        row_d = (row_q >= LAST_POS) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  assign s2_valid_d = emit || (s2_valid_q && !out_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RGB;
      col_q       <= '0;
      row_q       <= '0;
      pair_q      <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= pixel_mode_e'(cfg_wdata_i);
      end
      col_q      <= col_d;
      row_q      <= row_d;
      pair_q     <= pair_d;
      s2_valid_q <= s2_valid_d;
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s2_top_q  <= top_rd;
      s2_bot_q  <= pair_new;
      s2_done_q <= (row_q == LAST_POS) && (col_q == LAST_POS);
    end
    if (out_ready && s2_valid_q) begin
      out_pix_q  <= out_pix_d;
      out_done_q <= s2_done_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign averaged_pixel_o = out_pix_q;
  assign tile_done_o      = out_done_q;

endmodule
